FILE: rtl/e2q_pkg.sv
// Package for the Euler-angle to quaternion converter.
// Holds the CORDIC constants, the lane types and the Q30 rounding multiply.
// No dependencies.
`default_nettype none
package e2q_pkg;

	localparam int ANGLE_BITS_DEF    = 16;
	localparam int FRACTION_BITS_DEF = 14;
	localparam int FIELD_BITS        = 16;
	localparam int CORDIC_STEPS      = 28;
	localparam int LANES             = 3;
	// Datapath width of the rotators and products in Q30.
	localparam int CW                = 34;

	localparam logic [31:0] PI_Q30           = 32'd3373259426;
	localparam logic signed [CW-1:0] GAIN_Q30 = CW'(652032874);

	typedef logic signed [FIELD_BITS-1:0] field_t;
	typedef logic signed [CW-1:0] word_t;

	typedef struct packed {
		word_t x;
		word_t y;
		word_t z;
		logic  neg;
	} lane_t;

	typedef lane_t [LANES-1:0] lanes_t;

	function automatic word_t atan_q30(input int step);
		word_t r;
		case (step)
			0:  r = CW'(843314856);
			1:  r = CW'(497837829);
			2:  r = CW'(263043836);
			3:  r = CW'(133525158);
			4:  r = CW'(67021686);
			5:  r = CW'(33543515);
			6:  r = CW'(16775850);
			7:  r = CW'(8388437);
			8:  r = CW'(4194282);
			9:  r = CW'(2097149);
			10: r = CW'(1048575);
			11: r = CW'(524287);
			12: r = CW'(262143);
			13: r = CW'(131071);
			14: r = CW'(65535);
			15: r = CW'(32767);
			16: r = CW'(16383);
			17: r = CW'(8191);
			18: r = CW'(4095);
			19: r = CW'(2047);
			20: r = CW'(1023);
			21: r = CW'(511);
			22: r = CW'(255);
			23: r = CW'(127);
			24: r = CW'(63);
			25: r = CW'(31);
			26: r = CW'(15);
			27: r = CW'(7);
			default: r = '0;
		endcase
		return r;
	endfunction

	// Q30 product, rounded half up.
	function automatic word_t mul_q30(input word_t a, input word_t b);
		logic signed [2*CW-1:0] p;
		logic signed [2*CW-1:0] half;
		half = (2*CW)'(1) <<< 29;
		p = (2*CW)'(a) * (2*CW)'(b);
		p = p + half;
		return CW'(p >>> 30);
	endfunction

endpackage
`default_nettype wire

FILE: rtl/e2q_if.sv
// Stream channels of the converter: angle beats in, quaternion beats out.
// Depends on e2q_pkg.
`default_nettype none
interface e2q_in_if import e2q_pkg::*; ();
	logic   valid;
	logic   ready;
	field_t yaw_angle;
	field_t pitch_angle;
	field_t roll_angle;
	modport source (output valid, yaw_angle, pitch_angle, roll_angle, input ready);
	modport sink (input valid, yaw_angle, pitch_angle, roll_angle, output ready);
endinterface

interface e2q_out_if import e2q_pkg::*; ();
	logic   valid;
	logic   ready;
	field_t quat_w;
	field_t quat_x;
	field_t quat_y;
	field_t quat_z;
	modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
	modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface
`default_nettype wire

FILE: rtl/euler_to_quaternion.sv
// Euler angles (ZYX) to quaternion converter, top level.
// Pipeline: one angle stage, 28 CORDIC cells, three product stages.
// Throughput is one beat per cycle; the whole pipe advances unless the output
// register holds a beat that is not taken. Reset clears only the valid bits.
// Depends on e2q_pkg, e2q_if, e2q_prep, e2q_cell and e2q_combine.
`default_nettype none
module euler_to_quaternion import e2q_pkg::*; #(
	parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	e2q_in_if.sink    angles,
	e2q_out_if.source quat
);

	logic   en;
	field_t angle [LANES];
	logic   valid_c [CORDIC_STEPS+1];
	lanes_t lanes_c [CORDIC_STEPS+1];
	logic   valid_s3;
	field_t quat_s3 [4];

	assign en           = !valid_s3 || quat.ready;
	assign angles.ready = en;
	assign angle[0]     = angles.yaw_angle;
	assign angle[1]     = angles.pitch_angle;
	assign angle[2]     = angles.roll_angle;

	e2q_prep #(.ANGLE_BITS(ANGLE_BITS)) u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid    (angles.valid),
		.angle    (angle),
		.valid_s1 (valid_c[0]),
		.lanes_s1 (lanes_c[0])
	);

	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
		e2q_cell #(.STEP(g)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (valid_c[g]),
			.lanes_in (lanes_c[g]),
			.valid_q  (valid_c[g+1]),
			.lanes_q  (lanes_c[g+1])
		);
	end

	e2q_combine #(.FRACTION_BITS(FRACTION_BITS)) u_combine (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_in (valid_c[CORDIC_STEPS]),
		.lanes_in (lanes_c[CORDIC_STEPS]),
		.valid_s3 (valid_s3),
		.quat_s3  (quat_s3)
	);

	assign quat.valid  = valid_s3;
	assign quat.quat_w = quat_s3[0];
	assign quat.quat_x = quat_s3[1];
	assign quat.quat_y = quat_s3[2];
	assign quat.quat_z = quat_s3[3];

endmodule
`default_nettype wire

FILE: rtl/e2q_prep.sv
// Front stage: maps each binary angle to its half angle in Q30 radians.
// Depends on e2q_pkg.
`default_nettype none
module e2q_prep import e2q_pkg::*; #(
	parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   en,
	input  wire logic   valid,
	input  wire field_t angle [LANES],
	output logic        valid_s1,
	output lanes_t      lanes_s1
);

	lanes_t lanes_d;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			logic [ANGLE_BITS-1:0]  raw;
			logic [ANGLE_BITS-1:0]  mag;
			logic [ANGLE_BITS+31:0] prod;
			raw  = angle[i][ANGLE_BITS-1:0];
			// Two's complement negate also maps the most negative code to pi.
			mag  = raw[ANGLE_BITS-1] ? (~raw + 1'b1) : raw;
			if (raw[ANGLE_BITS-1] && mag == {1'b1, {(ANGLE_BITS-1){1'b0}}}) begin
				mag = {1'b1, {(ANGLE_BITS-1){1'b0}}};
			end
			prod = (ANGLE_BITS+32)'(mag) * (ANGLE_BITS+32)'(PI_Q30)
				+ ((ANGLE_BITS+32)'(1) << (ANGLE_BITS-1));
			lanes_d[i].z   = CW'(prod >> ANGLE_BITS);
			lanes_d[i].x   = GAIN_Q30;
			lanes_d[i].y   = '0;
			lanes_d[i].neg = raw[ANGLE_BITS-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lanes_s1 <= lanes_d;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/e2q_cell.sv
// One CORDIC rotation step for the three angle lanes, registered.
// Depends on e2q_pkg.
`default_nettype none
module e2q_cell import e2q_pkg::*; #(
	parameter int STEP = 0
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   en,
	input  wire logic   valid_in,
	input  wire lanes_t lanes_in,
	output logic        valid_q,
	output lanes_t      lanes_q
);

	localparam word_t ATAN = atan_q30(STEP);

	lanes_t lanes_d;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			word_t dx;
			word_t dy;
			dx = lanes_in[i].y >>> STEP;
			dy = lanes_in[i].x >>> STEP;
			lanes_d[i].neg = lanes_in[i].neg;
			if (!lanes_in[i].z[CW-1]) begin
				lanes_d[i].x = lanes_in[i].x - dx;
				lanes_d[i].y = lanes_in[i].y + dy;
				lanes_d[i].z = lanes_in[i].z - ATAN;
			end else begin
				lanes_d[i].x = lanes_in[i].x + dx;
				lanes_d[i].y = lanes_in[i].y - dy;
				lanes_d[i].z = lanes_in[i].z + ATAN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lanes_q <= lanes_d;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/e2q_combine.sv
// Triple-product stage: combines the cosine/sine pairs into w, x, y, z
// over three registered steps. Depends on e2q_pkg.
`default_nettype none
module e2q_combine import e2q_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   en,
	input  wire logic   valid_in,
	input  wire lanes_t lanes_in,
	output logic        valid_s3,
	output field_t      quat_s3 [4]
);

	localparam int SW = CW + 1;
	localparam logic signed [SW-1:0] ONE   = SW'(1) <<< FRACTION_BITS;
	localparam logic signed [SW-1:0] RHALF = SW'(1) <<< (29 - FRACTION_BITS);

	function automatic field_t to_out(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] r;
		r = (v + RHALF) >>> (30 - FRACTION_BITS);
		if (r > ONE) begin
			r = ONE;
		end
		if (r < -ONE) begin
			r = -ONE;
		end
		return r[FIELD_BITS-1:0];
	endfunction

	word_t cy, sy, cp, sp, cr, sr;
	logic  valid_s1, valid_s2;
	word_t cr_s1, sr_s1, cpcy_s1, spsy_s1, cpsy_s1, spcy_s1;
	word_t p_s2 [8];

	// Lane 0 is yaw, lane 1 pitch, lane 2 roll; the sine takes the angle's sign.
	always_comb begin
		cy = lanes_in[0].x;
		cp = lanes_in[1].x;
		cr = lanes_in[2].x;
		sy = lanes_in[0].neg ? -lanes_in[0].y : lanes_in[0].y;
		sp = lanes_in[1].neg ? -lanes_in[1].y : lanes_in[1].y;
		sr = lanes_in[2].neg ? -lanes_in[2].y : lanes_in[2].y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cr_s1   <= cr;
			sr_s1   <= sr;
			cpcy_s1 <= mul_q30(cp, cy);
			spsy_s1 <= mul_q30(sp, sy);
			cpsy_s1 <= mul_q30(cp, sy);
			spcy_s1 <= mul_q30(sp, cy);

			p_s2[0] <= mul_q30(cr_s1, cpcy_s1);
			p_s2[1] <= mul_q30(sr_s1, spsy_s1);
			p_s2[2] <= mul_q30(sr_s1, cpcy_s1);
			p_s2[3] <= mul_q30(cr_s1, spsy_s1);
			p_s2[4] <= mul_q30(cr_s1, spcy_s1);
			p_s2[5] <= mul_q30(sr_s1, cpsy_s1);
			p_s2[6] <= mul_q30(cr_s1, cpsy_s1);
			p_s2[7] <= mul_q30(sr_s1, spcy_s1);

			quat_s3[0] <= to_out(SW'(p_s2[0]) + SW'(p_s2[1]));
			quat_s3[1] <= to_out(SW'(p_s2[2]) - SW'(p_s2[3]));
			quat_s3[2] <= to_out(SW'(p_s2[4]) + SW'(p_s2[5]));
			quat_s3[3] <= to_out(SW'(p_s2[6]) - SW'(p_s2[7]));
		end
	end

endmodule
`default_nettype wire

FILE: dv/euler_to_quaternion_test.sv
// Self-checking testbench for euler_to_quaternion: drives angle beats with random gaps,
// predicts each quaternion with a bit-exact CORDIC model and compares every output beat.
// Depends on e2q_pkg, e2q_if and the converter RTL.
`default_nettype none
module euler_to_quaternion_test;
	import e2q_pkg::*;

	typedef struct packed {
		field_t w;
		field_t x;
		field_t y;
		field_t z;
	} quat_t;

	localparam int LATENCY = 32;
	localparam int STALL_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	e2q_in_if angles ();
	e2q_out_if quat ();

	euler_to_quaternion DUT (
		.clk(clk),
		.arst_n(arst_n),
		.angles(angles.sink),
		.quat(quat.source)
	);

	always #1 clk = ~clk;

	quat_t pending_quats[$];
	int errors = 0;
	int beats_sent = 0;
	int beats_checked = 0;
	int idle_cycles = 0;
	bit sink_busy_mode = 1'b0;
	bit no_gaps = 1'b0;

	localparam longint ATAN_TABLE [CORDIC_STEPS] = '{
		843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
		16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
		131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
		127, 63, 31, 15, 7
	};

	// Q30 product rounded half up; SystemVerilog >>> on signed longint floors.
	function automatic longint round_q30(input longint a, input longint b);
		longint p;
		p = a * b + (64'sd1 <<< 29);
		return p >>> 30;
	endfunction

	// Cosine and sine in Q30 of half the binary angle.
	function automatic void half_angle_trig(input field_t ang, output longint c,
			output longint s);
		bit neg;
		longint mag;
		longint z;
		longint x;
		longint y;
		longint dx;
		longint dy;
		neg = ang[15];
		mag = neg ? (65536 - longint'({1'b0, ang[15:0]})) : longint'({1'b0, ang[15:0]});
		z = (mag * 64'sd3373259426 + 32768) >>> 16;
		x = 652032874;
		y = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= ATAN_TABLE[i];
			end else begin
				x += dx;
				y -= dy;
				z += ATAN_TABLE[i];
			end
		end
		c = x;
		s = neg ? -y : y;
	endfunction

	function automatic field_t saturate_q14(input longint v);
		longint r;
		r = (v + (64'sd1 <<< 15)) >>> 16;
		if (r > 16384)
			r = 16384;
		if (r < -16384)
			r = -16384;
		return field_t'(r);
	endfunction

	function automatic quat_t predict_quat(input field_t yaw, input field_t pitch,
			input field_t roll);
		longint cy, sy, cp, sp, cr, sr;
		longint cpcy, spsy, cpsy, spcy;
		quat_t q;
		half_angle_trig(yaw, cy, sy);
		half_angle_trig(pitch, cp, sp);
		half_angle_trig(roll, cr, sr);
		cpcy = round_q30(cp, cy);
		spsy = round_q30(sp, sy);
		cpsy = round_q30(cp, sy);
		spcy = round_q30(sp, cy);
		q.w = saturate_q14(round_q30(cr, cpcy) + round_q30(sr, spsy));
		q.x = saturate_q14(round_q30(sr, cpcy) - round_q30(cr, spsy));
		q.y = saturate_q14(round_q30(cr, spcy) + round_q30(sr, cpsy));
		q.z = saturate_q14(round_q30(cr, cpsy) - round_q30(sr, spcy));
		return q;
	endfunction

	task automatic report_mismatch(input string what, input field_t got, input field_t want);
		errors++;
		$display("mismatch on beat %0d: %s got %0d expected %0d",
			beats_checked, what, got, want);
	endtask

	// Sends one angle beat after a random gap (none when no_gaps is set); the prediction is queued at acceptance.
	task automatic send_angles(input field_t yaw, input field_t pitch, input field_t roll);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(17, 0);
		if (gap != 0) begin
			angles.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		angles.valid <= 1'b1;
		angles.yaw_angle <= yaw;
		angles.pitch_angle <= pitch;
		angles.roll_angle <= roll;
		@(posedge clk);
		while (!angles.ready)
			@(posedge clk);
		pending_quats.push_back(predict_quat(yaw, pitch, roll));
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic finish_stream;
		angles.valid <= 1'b0;
	endtask

	// Output side: before each beat is taken, ready is held low for a randomly drawn stall length.
	initial begin
		int stall;
		quat.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = (no_gaps && !sink_busy_mode) ? 0 : $urandom_range(17, 0);
			if (stall != 0) begin
				quat.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			quat.ready <= 1'b1;
			@(posedge clk);
			while (!quat.valid)
				@(posedge clk);
		end
	end

	always @(posedge clk) begin
		quat_t want;
		if (arst_n && quat.valid && quat.ready) begin
			if (pending_quats.size() == 0) begin
				errors++;
				$display("unexpected quaternion beat %0d %0d %0d %0d",
					quat.quat_w, quat.quat_x, quat.quat_y, quat.quat_z);
			end else begin
				want = pending_quats.pop_front();
				if (quat.quat_w !== want.w)
					report_mismatch("w", quat.quat_w, want.w);
				if (quat.quat_x !== want.x)
					report_mismatch("x", quat.quat_x, want.x);
				if (quat.quat_y !== want.y)
					report_mismatch("y", quat.quat_y, want.y);
				if (quat.quat_z !== want.z)
					report_mismatch("z", quat.quat_z, want.z);
			end
			beats_checked++;
		end
	end

	// Watchdog on cycles in which neither channel moves a beat.
	always @(posedge clk) begin
		if ((angles.valid && angles.ready) || (quat.valid && quat.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("no beat for %0d cycles, %0d results outstanding",
				idle_cycles, pending_quats.size());
			$display("FAILURE");
			$finish;
		end
	end

	task automatic test_extremes;
		field_t corners [6] = '{16'sh8000, 16'sh8001, 16'shffff, 16'sh0000, 16'sh0001,
			16'sh7fff};
		for (int i = 0; i < 6; i++)
			send_angles(corners[i], corners[i], corners[i]);
		// Half-pi (minus on pitch) on single axes, the most negative angle (pi) on each axis alone, then mixed sets.
		send_angles(16'sh4000, 16'sh0000, 16'sh0000);
		send_angles(16'sh0000, 16'shc000, 16'sh0000);
		send_angles(16'sh0000, 16'sh0000, 16'sh4000);
		send_angles(16'sh8000, 16'sh0000, 16'sh0000);
		send_angles(16'sh0000, 16'sh8000, 16'sh0000);
		send_angles(16'sh0000, 16'sh0000, 16'sh8000);
		send_angles(16'sh7fff, 16'sh8000, 16'sh7fff);
		send_angles(16'sh8000, 16'sh7fff, 16'sh8000);
		send_angles(16'sh2000, 16'sh2000, 16'sh2000);
		send_angles(16'sh5555, 16'shaaaa, 16'sh5555);
		send_angles(16'shaaaa, 16'sh5555, 16'shaaaa);
	endtask

	task automatic test_random_angles(input int count);
		for (int i = 0; i < count; i++)
			send_angles(field_t'($urandom), field_t'($urandom), field_t'($urandom));
	endtask

	// Angles near -pi, zero and +pi (some random), where rounding toward saturation is most likely.
	task automatic test_edge_angles(input int count);
		field_t pick [3];
		for (int i = 0; i < count; i++) begin
			for (int k = 0; k < 3; k++) begin
				case ($urandom_range(3, 0))
					0: pick[k] = field_t'(16'sh8000 + $urandom_range(8, 0));
					1: pick[k] = field_t'(16'sh7fff - $urandom_range(8, 0));
					2: pick[k] = field_t'($urandom_range(16, 0) - 8);
					default: pick[k] = field_t'($urandom);
				endcase
			end
			send_angles(pick[0], pick[1], pick[2]);
		end
	endtask

	task automatic test_back_to_back(input int count);
		no_gaps = 1'b1;
		test_random_angles(count);
		sink_busy_mode = 1'b1;
		test_random_angles(count);
		sink_busy_mode = 1'b0;
		no_gaps = 1'b0;
	endtask

	initial begin
		int drain;
		angles.valid = 1'b0;
		angles.yaw_angle = '0;
		angles.pitch_angle = '0;
		angles.roll_angle = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_extremes();
		test_random_angles(900);
		test_edge_angles(300);
		test_back_to_back(100);
		finish_stream();
		drain = 0;
		while (pending_quats.size() != 0 && drain < 100000) begin
			@(posedge clk);
			drain++;
		end
		repeat (2 * LATENCY) @(posedge clk);
		$display("sent %0d angle beats, checked %0d quaternion beats", beats_sent,
			beats_checked);
		$display("covered extremes, random and near-limit angles, with and without stalls");
		if (errors == 0 && pending_quats.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
`default_nettype wire

FILE: files.f
rtl/e2q_pkg.sv
rtl/e2q_if.sv
rtl/e2q_prep.sv
rtl/e2q_cell.sv
rtl/e2q_combine.sv
rtl/euler_to_quaternion.sv
dv/euler_to_quaternion_test.sv
